FILE: hw/rtl/rvau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rvau_pkg;

    // CORDIC length and the arctangent table behind it.
    localparam int CORDIC_STAGES = 24;
    localparam int ATAN_ENTRIES  = 30;
    localparam int CORDIC_N      = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

    // Iteration counts of the square root and of the dividers.
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;

    // Pipeline stage indexes.
    localparam int ST_IN     = 0;
    localparam int ST_SQ     = ST_IN + 1;
    localparam int ST_SUM    = ST_SQ + 1;
    localparam int ST_SQRT0  = ST_SUM + 1;
    localparam int ST_RED    = ST_SQRT0 + SQRT_STEPS;
    localparam int ST_FOLD   = ST_RED + 1;
    localparam int ST_CORD0  = ST_FOLD + 1;
    localparam int ST_MUL    = ST_CORD0 + CORDIC_N;
    localparam int ST_DIV0   = ST_MUL + 1;
    localparam int ST_PROD   = ST_DIV0 + DIV_STEPS;
    localparam int ST_PSUM   = ST_PROD + 1;
    localparam int ST_OUT    = ST_PSUM + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    // Fixed-point constants, Q.30 angles and unit values.
    localparam logic [32:0]        TWO_PI_U   = 33'd6746518852;
    localparam logic signed [33:0] TWO_PI_S   = 34'sd6746518852;
    localparam logic signed [33:0] PI_S       = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_S  = 34'sd1686629713;
    localparam logic signed [33:0] CORDIC_K   = 34'sd652032874;
    localparam logic signed [33:0] ONE_S34    = 34'sd1073741824;
    localparam logic signed [31:0] ONE_Q30    = 32'sd1073741824;
    localparam logic signed [65:0] HALF_LSB   = 66'sd536870912;
    localparam logic signed [35:0] OUT_MAX    = 36'sd2147483647;
    localparam logic signed [35:0] OUT_MIN    = -36'sd2147483648;

    typedef struct packed {
        logic              action;
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_w;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic              saturated;
    } t_out;

    // Everything one item carries down the pipeline.
    typedef struct packed {
        logic              action;
        logic [3:0][31:0]  q;
        logic [2:0][31:0]  v;
        logic [2:0][63:0]  sq;
        logic [63:0]       srem;
        logic [63:0]       sres;
        logic [31:0]       n;
        logic              zero;
        logic signed [33:0] ang;
        logic              flip;
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic signed [33:0] ca;
        logic [31:0]       cos_v;
        logic [2:0][61:0]  dmag;
        logic [2:0]        dneg;
        logic [2:0][32:0]  drem;
        logic [2:0][30:0]  dquo;
        logic [15:0][63:0] prod;
        logic [7:0][64:0]  psum;
        logic [3:0][31:0]  ow;
        logic              osat;
    } t_pipe;

    // One term of the Hamilton product: operand indexes and sign.
    typedef struct packed {
        logic       neg;
        logic [1:0] ai;
        logic [1:0] bi;
    } t_term;

    function automatic logic [29:0] atan_q30(input int idx);
        logic [29:0] val;
        unique case (idx)
            0:  val = 30'd843314856;
            1:  val = 30'd497837829;
            2:  val = 30'd263043836;
            3:  val = 30'd133525158;
            4:  val = 30'd67021686;
            5:  val = 30'd33543515;
            6:  val = 30'd16775850;
            7:  val = 30'd8388437;
            8:  val = 30'd4194282;
            9:  val = 30'd2097149;
            10: val = 30'd1048575;
            11: val = 30'd524287;
            12: val = 30'd262143;
            13: val = 30'd131071;
            14: val = 30'd65535;
            15: val = 30'd32767;
            16: val = 30'd16383;
            17: val = 30'd8191;
            18: val = 30'd4095;
            19: val = 30'd2047;
            20: val = 30'd1023;
            21: val = 30'd511;
            22: val = 30'd255;
            23: val = 30'd127;
            24: val = 30'd63;
            25: val = 30'd31;
            26: val = 30'd15;
            27: val = 30'd7;
            28: val = 30'd3;
            29: val = 30'd1;
            default: val = 30'd0;
        endcase
        return val;
    endfunction

    // Four terms per output component, w, x, y, z in turn.
    function automatic t_term hamilton_term(input int idx);
        t_term t;
        unique case (idx)
            0:  t = '{neg: 1'b0, ai: 2'd0, bi: 2'd0};
            1:  t = '{neg: 1'b1, ai: 2'd1, bi: 2'd1};
            2:  t = '{neg: 1'b1, ai: 2'd2, bi: 2'd2};
            3:  t = '{neg: 1'b1, ai: 2'd3, bi: 2'd3};
            4:  t = '{neg: 1'b0, ai: 2'd0, bi: 2'd1};
            5:  t = '{neg: 1'b0, ai: 2'd1, bi: 2'd0};
            6:  t = '{neg: 1'b0, ai: 2'd2, bi: 2'd3};
            7:  t = '{neg: 1'b1, ai: 2'd3, bi: 2'd2};
            8:  t = '{neg: 1'b0, ai: 2'd0, bi: 2'd2};
            9:  t = '{neg: 1'b0, ai: 2'd2, bi: 2'd0};
            10: t = '{neg: 1'b0, ai: 2'd3, bi: 2'd1};
            11: t = '{neg: 1'b1, ai: 2'd1, bi: 2'd3};
            12: t = '{neg: 1'b0, ai: 2'd0, bi: 2'd3};
            13: t = '{neg: 1'b0, ai: 2'd3, bi: 2'd0};
            14: t = '{neg: 1'b0, ai: 2'd1, bi: 2'd2};
            15: t = '{neg: 1'b1, ai: 2'd2, bi: 2'd1};
            default: t = '{neg: 1'b0, ai: 2'd0, bi: 2'd0};
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rotation_vector_attitude_update.sv
// Rotation-vector attitude update.
// Input channel (i_in_valid, i_in_data, o_in_stall) carries an attitude
// quaternion in Q2.30, a rotation vector in Q3.28 and an action bit. Action 0
// returns q times r, action 1 returns r times q, where r is the rotation
// quaternion of the vector. Output channel (o_out_valid, o_out_data,
// i_out_stall) returns the saturated Q2.30 product and a clip flag.
// A transfer happens on a clock edge with valid high and stall low.
// Throughput is one item per cycle while the receiver does not stall. The
// pipeline's stages include 32 square-root stages, the CORDIC stages and
// 31 restoring-divider stages.
// Each full stage holds while the stage after it is full and stalled, so bubbles
// close up; the input stalls only when every stage holds an item and the
// receiver stalls. Nothing is lost or repeated under stall.
// The synchronous active-low reset clears all valid bits; the pipeline is
// empty and ready in the first cycle after reset is released.
`timescale 1ns / 1ps
`default_nettype none

module rotation_vector_attitude_update (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  rvau_pkg::t_in     i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output rvau_pkg::t_out    o_out_data,
    input  wire               i_out_stall
);

    localparam int NS = rvau_pkg::NUM_STAGES;

    rvau_pkg::t_pipe n_p [NS];
    rvau_pkg::t_pipe r_p [NS];
    logic            r_v [NS];
    logic            en  [NS+1];

    // Stage enables: a stage moves when it is empty or the next one moves.
    assign en[NS] = !i_out_stall;
    for (genvar k = 0; k < NS; k++) begin : g_en
        assign en[k] = !r_v[k] || en[k+1];
    end

    // Valid bits and payload registers of every stage.
    for (genvar k = 0; k < NS; k++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en[k]) begin
                if (k == 0) begin
                    r_v[k] <= i_in_valid;
                end else begin
                    r_v[k] <= r_v[(k == 0) ? 0 : k-1];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_p[k] <= n_p[k];
            end
        end
    end

    // Input capture.
    always_comb begin
        n_p[rvau_pkg::ST_IN] = '0;
        n_p[rvau_pkg::ST_IN].action = i_in_data.action;
        n_p[rvau_pkg::ST_IN].q[0] = i_in_data.quat_w;
        n_p[rvau_pkg::ST_IN].q[1] = i_in_data.quat_x;
        n_p[rvau_pkg::ST_IN].q[2] = i_in_data.quat_y;
        n_p[rvau_pkg::ST_IN].q[3] = i_in_data.quat_z;
        n_p[rvau_pkg::ST_IN].v[0] = i_in_data.rot_x;
        n_p[rvau_pkg::ST_IN].v[1] = i_in_data.rot_y;
        n_p[rvau_pkg::ST_IN].v[2] = i_in_data.rot_z;
    end

    // Squares of the vector component magnitudes.
    always_comb begin
        logic [31:0] m;
        n_p[rvau_pkg::ST_SQ] = r_p[rvau_pkg::ST_SQ-1];
        for (int i = 0; i < 3; i++) begin
            m = r_p[rvau_pkg::ST_SQ-1].v[i][31] ? (~r_p[rvau_pkg::ST_SQ-1].v[i] + 32'd1)
                                                : r_p[rvau_pkg::ST_SQ-1].v[i];
            n_p[rvau_pkg::ST_SQ].sq[i] = {32'd0, m} * {32'd0, m};
        end
    end

    // Sum of squares seeds the square root.
    always_comb begin
        n_p[rvau_pkg::ST_SUM] = r_p[rvau_pkg::ST_SUM-1];
        n_p[rvau_pkg::ST_SUM].srem = r_p[rvau_pkg::ST_SUM-1].sq[0]
                                   + r_p[rvau_pkg::ST_SUM-1].sq[1]
                                   + r_p[rvau_pkg::ST_SUM-1].sq[2];
        n_p[rvau_pkg::ST_SUM].sres = '0;
    end

    // Bit-serial square root, one result bit per stage.
    for (genvar i = 0; i < rvau_pkg::SQRT_STEPS; i++) begin : g_sqrt
        localparam int K = rvau_pkg::ST_SQRT0 + i;
        localparam logic [63:0] BIT = 64'd1 << (62 - 2*i);
        always_comb begin
            logic [63:0] t;
            n_p[K] = r_p[K-1];
            t = r_p[K-1].sres + BIT;
            if (r_p[K-1].srem >= t) begin
                n_p[K].srem = r_p[K-1].srem - t;
                n_p[K].sres = (r_p[K-1].sres >> 1) + BIT;
            end else begin
                n_p[K].sres = r_p[K-1].sres >> 1;
            end
        end
    end

    // Half-angle reduction modulo two pi.
    always_comb begin
        logic [32:0] h;
        logic [32:0] hm;
        logic signed [33:0] a;
        n_p[rvau_pkg::ST_RED] = r_p[rvau_pkg::ST_RED-1];
        n_p[rvau_pkg::ST_RED].n = r_p[rvau_pkg::ST_RED-1].sres[31:0];
        n_p[rvau_pkg::ST_RED].zero = (r_p[rvau_pkg::ST_RED-1].sres[31:0] == 32'd0);
        h = {r_p[rvau_pkg::ST_RED-1].sres[31:0], 1'b0};
        hm = (h >= rvau_pkg::TWO_PI_U) ? (h - rvau_pkg::TWO_PI_U) : h;
        a = $signed({1'b0, hm});
        if (a > rvau_pkg::PI_S) begin
            a = a - rvau_pkg::TWO_PI_S;
        end
        n_p[rvau_pkg::ST_RED].ang = a;
    end

    // Fold into the right half plane and load the CORDIC.
    always_comb begin
        logic signed [33:0] a;
        n_p[rvau_pkg::ST_FOLD] = r_p[rvau_pkg::ST_FOLD-1];
        a = r_p[rvau_pkg::ST_FOLD-1].ang;
        priority if (a > rvau_pkg::HALF_PI_S) begin
            n_p[rvau_pkg::ST_FOLD].ca = rvau_pkg::PI_S - a;
            n_p[rvau_pkg::ST_FOLD].flip = 1'b1;
        end else if (a < -rvau_pkg::HALF_PI_S) begin
            n_p[rvau_pkg::ST_FOLD].ca = -rvau_pkg::PI_S - a;
            n_p[rvau_pkg::ST_FOLD].flip = 1'b1;
        end else begin
            n_p[rvau_pkg::ST_FOLD].ca = a;
            n_p[rvau_pkg::ST_FOLD].flip = 1'b0;
        end
        n_p[rvau_pkg::ST_FOLD].cx = rvau_pkg::CORDIC_K;
        n_p[rvau_pkg::ST_FOLD].cy = '0;
    end

    // CORDIC rotation, one micro-rotation per stage.
    for (genvar i = 0; i < rvau_pkg::CORDIC_N; i++) begin : g_cordic
        localparam int K = rvau_pkg::ST_CORD0 + i;
        localparam logic signed [33:0] ATAN = $signed({4'd0, rvau_pkg::atan_q30(i)});
        always_comb begin
            logic signed [33:0] x;
            logic signed [33:0] y;
            n_p[K] = r_p[K-1];
            x = r_p[K-1].cx;
            y = r_p[K-1].cy;
            if (!r_p[K-1].ca[33]) begin
                n_p[K].cx = x - (y >>> i);
                n_p[K].cy = y + (x >>> i);
                n_p[K].ca = r_p[K-1].ca - ATAN;
            end else begin
                n_p[K].cx = x + (y >>> i);
                n_p[K].cy = y - (x >>> i);
                n_p[K].ca = r_p[K-1].ca + ATAN;
            end
        end
    end

    // Clamp cos and sin, then scale the vector by sin for the dividers.
    always_comb begin
        logic signed [33:0] xf;
        logic signed [33:0] sc;
        logic signed [31:0] sn;
        logic signed [63:0] num;
        logic [63:0] mag;
        n_p[rvau_pkg::ST_MUL] = r_p[rvau_pkg::ST_MUL-1];
        xf = r_p[rvau_pkg::ST_MUL-1].flip ? -r_p[rvau_pkg::ST_MUL-1].cx
                                          : r_p[rvau_pkg::ST_MUL-1].cx;
        if (xf > rvau_pkg::ONE_S34) begin
            xf = rvau_pkg::ONE_S34;
        end else if (xf < -rvau_pkg::ONE_S34) begin
            xf = -rvau_pkg::ONE_S34;
        end
        sc = r_p[rvau_pkg::ST_MUL-1].cy;
        if (sc > rvau_pkg::ONE_S34) begin
            sc = rvau_pkg::ONE_S34;
        end else if (sc < -rvau_pkg::ONE_S34) begin
            sc = -rvau_pkg::ONE_S34;
        end
        n_p[rvau_pkg::ST_MUL].cos_v = xf[31:0];
        sn = sc[31:0];
        for (int i = 0; i < 3; i++) begin
            num = $signed(r_p[rvau_pkg::ST_MUL-1].v[i]) * sn;
            mag = num[63] ? 64'(-num) : 64'(num);
            n_p[rvau_pkg::ST_MUL].dneg[i] = num[63];
            n_p[rvau_pkg::ST_MUL].dmag[i] = mag[61:0];
            n_p[rvau_pkg::ST_MUL].drem[i] = {2'b00, mag[61:31]};
            n_p[rvau_pkg::ST_MUL].dquo[i] = '0;
        end
    end

    // Restoring division by the norm, one quotient bit per stage.
    for (genvar j = 0; j < rvau_pkg::DIV_STEPS; j++) begin : g_div
        localparam int K = rvau_pkg::ST_DIV0 + j;
        localparam int B = rvau_pkg::DIV_STEPS - 1 - j;
        always_comb begin
            logic [32:0] t;
            n_p[K] = r_p[K-1];
            for (int i = 0; i < 3; i++) begin
                t = {r_p[K-1].drem[i][31:0], r_p[K-1].dmag[i][B]};
                if (t >= {1'b0, r_p[K-1].n}) begin
                    n_p[K].drem[i] = t - {1'b0, r_p[K-1].n};
                    n_p[K].dquo[i][B] = 1'b1;
                end else begin
                    n_p[K].drem[i] = t;
                    n_p[K].dquo[i][B] = 1'b0;
                end
            end
        end
    end

    // Rotation quaternion, operand order and the sixteen products.
    always_comb begin
        logic [3:0][31:0] r;
        logic [3:0][31:0] a;
        logic [3:0][31:0] b;
        logic signed [63:0] p;
        rvau_pkg::t_term tm;
        n_p[rvau_pkg::ST_PROD] = r_p[rvau_pkg::ST_PROD-1];
        r[0] = r_p[rvau_pkg::ST_PROD-1].zero ? rvau_pkg::ONE_Q30
                                             : r_p[rvau_pkg::ST_PROD-1].cos_v;
        for (int i = 0; i < 3; i++) begin
            if (r_p[rvau_pkg::ST_PROD-1].zero) begin
                r[i+1] = '0;
            end else if (r_p[rvau_pkg::ST_PROD-1].dneg[i]) begin
                r[i+1] = -{1'b0, r_p[rvau_pkg::ST_PROD-1].dquo[i]};
            end else begin
                r[i+1] = {1'b0, r_p[rvau_pkg::ST_PROD-1].dquo[i]};
            end
        end
        if (r_p[rvau_pkg::ST_PROD-1].action) begin
            a = r;
            b = r_p[rvau_pkg::ST_PROD-1].q;
        end else begin
            a = r_p[rvau_pkg::ST_PROD-1].q;
            b = r;
        end
        for (int t = 0; t < 16; t++) begin
            tm = rvau_pkg::hamilton_term(t);
            p = $signed(a[tm.ai]) * $signed(b[tm.bi]);
            n_p[rvau_pkg::ST_PROD].prod[t] = tm.neg ? -p : p;
        end
    end

    // Pairwise sums of the products.
    always_comb begin
        n_p[rvau_pkg::ST_PSUM] = r_p[rvau_pkg::ST_PSUM-1];
        for (int j = 0; j < 8; j++) begin
            n_p[rvau_pkg::ST_PSUM].psum[j] =
                {r_p[rvau_pkg::ST_PSUM-1].prod[2*j][63], r_p[rvau_pkg::ST_PSUM-1].prod[2*j]}
              + {r_p[rvau_pkg::ST_PSUM-1].prod[2*j+1][63],
                 r_p[rvau_pkg::ST_PSUM-1].prod[2*j+1]};
        end
    end

    // Final sum, round to nearest and saturate.
    always_comb begin
        logic signed [65:0] tot;
        logic signed [35:0] v;
        logic sat;
        n_p[rvau_pkg::ST_OUT] = r_p[rvau_pkg::ST_OUT-1];
        sat = 1'b0;
        for (int c = 0; c < 4; c++) begin
            tot = $signed({r_p[rvau_pkg::ST_OUT-1].psum[2*c][64],
                           r_p[rvau_pkg::ST_OUT-1].psum[2*c]})
                + $signed({r_p[rvau_pkg::ST_OUT-1].psum[2*c+1][64],
                           r_p[rvau_pkg::ST_OUT-1].psum[2*c+1]})
                + rvau_pkg::HALF_LSB;
            v = tot[65:30];
            if (v > rvau_pkg::OUT_MAX) begin
                v = rvau_pkg::OUT_MAX;
                sat = 1'b1;
            end else if (v < rvau_pkg::OUT_MIN) begin
                v = rvau_pkg::OUT_MIN;
                sat = 1'b1;
            end
            n_p[rvau_pkg::ST_OUT].ow[c] = v[31:0];
        end
        n_p[rvau_pkg::ST_OUT].osat = sat;
    end

    // Output channel.
    assign o_in_stall  = !en[0];
    assign o_out_valid = r_v[NS-1];
    always_comb begin
        o_out_data.out_w     = r_p[NS-1].ow[0];
        o_out_data.out_x     = r_p[NS-1].ow[1];
        o_out_data.out_y     = r_p[NS-1].ow[2];
        o_out_data.out_z     = r_p[NS-1].ow[3];
        o_out_data.saturated = r_p[NS-1].osat;
    end

`ifndef SYNTHESIS
    // The input only stalls when the receiver holds a full pipeline.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

    // A clip flag means some component sits on a rail.
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.saturated) |->
            (o_out_data.out_w == 32'sh7fffffff || o_out_data.out_w == 32'sh80000000 ||
             o_out_data.out_x == 32'sh7fffffff || o_out_data.out_x == 32'sh80000000 ||
             o_out_data.out_y == 32'sh7fffffff || o_out_data.out_y == 32'sh80000000 ||
             o_out_data.out_z == 32'sh7fffffff || o_out_data.out_z == 32'sh80000000))
        else $error("saturation flag without a clipped component");

    // The square root leaves a remainder no larger than twice the root.
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[rvau_pkg::ST_RED-1] |->
            (r_p[rvau_pkg::ST_RED-1].srem <= (r_p[rvau_pkg::ST_RED-1].sres << 1)))
        else $error("square root remainder out of bound");

    // The clamped cosine stays within one.
    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[rvau_pkg::ST_MUL] |->
            ($signed(r_p[rvau_pkg::ST_MUL].cos_v) <= rvau_pkg::ONE_Q30 &&
             $signed(r_p[rvau_pkg::ST_MUL].cos_v) >= -rvau_pkg::ONE_Q30))
        else $error("cosine out of range");
`endif

endmodule

`default_nettype wire
